// ===== sv/itls_pkg.sv =====
package itls_pkg;

	localparam int MAX_TRANS = 16;
	localparam int IDX_W     = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
	localparam int CNT_W     = $clog2(MAX_TRANS + 1);
	localparam int LEN_W     = 9;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_EVENT = 2'd2;

	localparam logic [2:0] FIN_NONE  = 3'd0;
	localparam logic [2:0] FIN_OK    = 3'd1;
	localparam logic [2:0] FIN_PARAM = 3'd2;
	localparam logic [2:0] FIN_ARB   = 3'd3;
	localparam logic [2:0] FIN_NACK  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                    en;
		logic [IDX_W-1:0]        addr;
		logic signed [LEN_W-1:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic       issue_start;
		logic       issue_write;
		logic       issue_read;
		logic       send_nack;
		logic       issue_stop;
		logic       clear_int;
		logic       tx_load;
		logic [7:0] tx_value;
		logic       tx_taken;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic [2:0] finish;
	} result_t;

endpackage

// ===== sv/itls_table.sv =====
module itls_table (
	input  logic                                  clk,
	input  itls_pkg::tbl_wr_t                     wr,
	input  logic [itls_pkg::IDX_W-1:0]            rd_addr,
	output logic signed [itls_pkg::LEN_W-1:0]     rd_data
);
	import itls_pkg::*;

	logic signed [LEN_W-1:0] len_q [MAX_TRANS];
	logic signed [LEN_W-1:0] rd_q;

	// registered read: rd_data shows the entry addressed in the previous cycle
	always_ff @(posedge clk) begin
		if (wr.en) begin
			len_q[wr.addr] <= wr.data;
		end
		rd_q <= len_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ===== sv/i2c_transaction_list_sequencer.sv =====
// I2C transaction list sequencer for one slave. Feed items on the s_ stream with the
// command in s_tuser: a load item writes one signed length into the 16-entry table
// (positive writes, negative reads, zero skips), a start item begins the list at its
// first non-empty entry and commands a start with the address byte, and a bus event
// item advances the running transaction. Every accepted item yields exactly one
// result beat on the m_ stream carrying the bus commands and a finish code
// (1 ok, 2 bad parameter, 3 arbitration lost, 4 not acked). The block takes one item
// at a time and accepts no new item until the result of the last one is registered; a
// start, or a bus event that moves on to the next transaction, first scans the table
// one entry at a time through the single table read port and entry counter. A finished
// result waits in the output register while the next item is already taken. The user
// must write the slave address on the cfg_ channel only while the block is idle; the
// block itself does not enforce this. Table entries never loaded read as garbage and
// must not be reached by a list.
module i2c_transaction_list_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// config: slave_addr[6:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// lsb up: desc_index[3:0], desc_length[12:4], trans_count[17:13], lost_arb[18],
	// rx_nack[19], rx_byte[27:20], tx_byte[35:28], zero pad[39:36]
	input  logic [39:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// lsb up: issue_start[0], issue_write[1], issue_read[2], send_nack[3],
	// issue_stop[4], clear_int[5], tx_load[6], tx_value[14:7], tx_taken[15],
	// rx_valid[16], rx_data[24:17], finish[27:25], zero pad[31:28]
	output logic [31:0] m_tdata
);
	import itls_pkg::*;

	state_t state_q, state_d;

	logic [6:0]              addr_q;
	logic [CNT_W-1:0]        list_q, list_d;
	logic [CNT_W-1:0]        cur_q, cur_d;
	logic signed [LEN_W-1:0] rem_q, rem_d;
	logic                    await_q, await_d;
	logic                    busy_q, busy_d;
	logic                    run_q, run_d;   // scan started by a bus event, not by start
	result_t                 res_q, res_d;
	logic                    m_tvalid_q;
	logic [31:0]             m_tdata_q;

	tbl_wr_t                 tbl_wr;
	logic signed [LEN_W-1:0] entry;

	// unpack the input beat
	logic [1:0]              cmd;
	logic [3:0]              desc_index;
	logic signed [LEN_W-1:0] desc_length;
	logic [4:0]              trans_count;
	logic                    lost_arb, rx_nack;
	logic [7:0]              rx_byte, tx_byte;

	assign cmd         = s_tuser;
	assign desc_index  = s_tdata[3:0];
	assign desc_length = s_tdata[12:4];
	assign trans_count = s_tdata[17:13];
	assign lost_arb    = s_tdata[18];
	assign rx_nack     = s_tdata[19];
	assign rx_byte     = s_tdata[27:20];
	assign tx_byte     = s_tdata[35:28];

	logic accept, out_free;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	// shared entry counter: one incrementer serves the scan, the advance and the last test
	logic [CNT_W:0] cur_inc;
	logic           last, scan_end, entry_zero;
	assign cur_inc    = {1'b0, cur_q} + (CNT_W+1)'(1);
	assign last       = cur_inc >= {1'b0, list_q};
	assign scan_end   = cur_q >= list_q;
	assign entry_zero = (entry == '0);

	// shared remaining counter: count toward zero from either side
	logic rem_zero, rem_pos;
	logic signed [LEN_W-1:0] rem_step;
	assign rem_zero = (rem_q == '0);
	assign rem_pos  = !rem_q[LEN_W-1] && !rem_zero;
	assign rem_step = rem_pos ? (rem_q - LEN_W'(1)) : (rem_q + LEN_W'(1));

	logic [CNT_W-1:0] n_sat;
	assign n_sat = (32'(trans_count) > MAX_TRANS) ? CNT_W'(MAX_TRANS) : CNT_W'(trans_count);

	logic advance_ev;
	assign advance_ev = (cmd == CMD_EVENT) && busy_q && !lost_arb && !rx_nack
		&& rem_zero && !last;

	// address the table with the next entry so the registered read lines up with cur_q
	itls_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_addr (cur_d[IDX_W-1:0]),
		.rd_data (entry)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (advance_ev ||
					    ((cmd == CMD_START) && !busy_q && (n_sat != '0))) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end || !entry_zero) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and result
	always_comb begin
		res_d       = res_q;
		list_d      = list_q;
		cur_d       = cur_q;
		rem_d       = rem_q;
		await_d     = await_q;
		busy_d      = busy_q;
		run_d       = run_q;
		tbl_wr.en   = 1'b0;
		tbl_wr.addr = IDX_W'(desc_index);
		tbl_wr.data = desc_length;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_d = '0;
					case (cmd)
						CMD_LOAD: begin
							tbl_wr.en = (32'(desc_index) < MAX_TRANS);
						end
						CMD_START: begin
							if (!busy_q) begin
								if (n_sat == '0) begin
									res_d.finish = FIN_PARAM;
								end else begin
									list_d = n_sat;
									cur_d  = '0;
									run_d  = 1'b0;
								end
							end
						end
						CMD_EVENT: begin
							if (busy_q) begin
								if (lost_arb) begin
									res_d.clear_int = 1'b1;
									res_d.finish    = FIN_ARB;
									busy_d          = 1'b0;
								end else if (rx_nack) begin
									res_d.clear_int = 1'b1;
									res_d.finish    = (rem_zero && last) ? FIN_OK : FIN_NACK;
									busy_d          = 1'b0;
								end else if (rem_zero) begin
									if (last) begin
										res_d.clear_int = 1'b1;
										res_d.finish    = FIN_OK;
										busy_d          = 1'b0;
									end else begin
										cur_d = cur_inc[CNT_W-1:0];
										run_d = 1'b1;
									end
								end else begin
									res_d.clear_int = 1'b1;
									if (rem_pos) begin
										res_d.tx_load     = 1'b1;
										res_d.tx_value    = tx_byte;
										res_d.tx_taken    = 1'b1;
										res_d.issue_write = 1'b1;
										rem_d             = rem_step;
									end else begin
										// first read event only arms the read
										if (!await_q) begin
											res_d.rx_valid = 1'b1;
											res_d.rx_data  = rx_byte;
											rem_d          = rem_step;
										end
										await_d          = 1'b0;
										res_d.issue_read = 1'b1;
									end
									if (rem_d == '0) begin
										res_d.send_nack  = 1'b1;
										res_d.issue_stop = last;
									end
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					// no non-empty entry left in the list
					if (run_q) begin
						res_d.clear_int  = 1'b1;
						res_d.issue_stop = 1'b1;
					end
					res_d.finish = FIN_PARAM;
					busy_d       = 1'b0;
				end else if (entry_zero) begin
					cur_d = cur_inc[CNT_W-1:0];
				end else begin
					rem_d             = entry;
					await_d           = 1'b1;
					res_d.tx_load     = 1'b1;
					res_d.tx_value    = {addr_q, entry[LEN_W-1]};
					res_d.issue_start = 1'b1;
					res_d.issue_write = 1'b1;
					res_d.clear_int   = 1'b1;
					busy_d            = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			addr_q     <= '0;
			list_q     <= '0;
			cur_q      <= '0;
			rem_q      <= '0;
			await_q    <= 1'b0;
			busy_q     <= 1'b0;
			run_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			list_q  <= list_d;
			cur_q   <= cur_d;
			rem_q   <= rem_d;
			await_q <= await_d;
			busy_q  <= busy_d;
			run_q   <= run_d;
			if (cfg_valid && cfg_ready) begin
				addr_q <= cfg_data;
			end
			// hand the finished result to the output register once it is free
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= {4'b0, res_q.finish, res_q.rx_data, res_q.rx_valid,
				res_q.tx_taken, res_q.tx_value, res_q.tx_load, res_q.clear_int,
				res_q.issue_stop, res_q.send_nack, res_q.issue_read,
				res_q.issue_write, res_q.issue_start};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== tb/i2c_transaction_list_sequencer_test.sv =====
`timescale 1ns / 100ps

module i2c_transaction_list_sequencer_test;
	import itls_pkg::*;

	// The package names three commands; the fourth code is a no-op.
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam bit TYPED = 1'b1;
	localparam bit PRED  = 1'b0;
	// Longest accept-to-result time: a full table scan plus the pipeline.
	localparam int DRAIN_CYCLES = 2 * MAX_TRANS + 8;
	localparam int HOLD_OFF_CYCLES = 400;

	// One input item, field for field.
	typedef struct {
		logic [1:0]        cmd;
		logic [3:0]        idx;
		logic signed [8:0] len;
		logic [4:0]        cnt;
		logic              arb;
		logic              nack;
		logic [7:0]        rxb;
		logic [7:0]        txb;
	} seq_item_t;

	// Directed row: item, and for obvious rows the typed finish and clear_int
	// (every other result field is zero on those rows).
	typedef struct {
		seq_item_t  item;
		bit         typed;
		logic [2:0] fin;
		bit         clr;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	// Predictor state: the length table, the running list and the address.
	logic signed [8:0] len_tbl [MAX_TRANS];
	int                list_len;
	int                entry_ptr;
	int                bytes_left;
	bit                first_rx_pending;
	bit                list_active;
	logic [6:0]        slave_addr_q;

	result_t   expected_cmds_q [$];
	dir_row_t  dir_tab [$];
	int        items_sent;
	int        mismatch_cnt;
	int        hold_cycles;
	bit        no_idle;

	i2c_transaction_list_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Scan forward from entry_ptr for a non-empty entry and, if one is found,
	// open it: load the address byte with the read flag and command a start.
	function automatic bit open_next_entry(inout result_t r);
		while (entry_ptr < list_len && len_tbl[entry_ptr] == 0)
			entry_ptr++;
		if (entry_ptr >= list_len)
			return 1'b0;
		bytes_left = len_tbl[entry_ptr];
		first_rx_pending = 1'b1;
		r.tx_value = {slave_addr_q, (bytes_left < 0) ? 1'b1 : 1'b0};
		r.tx_load = 1'b1;
		r.issue_start = 1'b1;
		r.issue_write = 1'b1;
		r.clear_int = 1'b1;
		return 1'b1;
	endfunction

	// Work out the bus commands that one accepted item causes, and advance
	// the predictor state.
	function automatic result_t predict_bus_cmd(seq_item_t it);
		result_t r;
		int      n;
		bit      last;
		r = '0;
		case (it.cmd)
			CMD_LOAD: len_tbl[it.idx] = it.len;
			CMD_START: begin
				if (!list_active) begin
					n = it.cnt;
					if (n > MAX_TRANS)
						n = MAX_TRANS;
					if (n == 0) begin
						r.finish = FIN_PARAM;
					end else begin
						list_len = n;
						entry_ptr = 0;
						if (open_next_entry(r))
							list_active = 1'b1;
						else
							r.finish = FIN_PARAM;
					end
				end
			end
			CMD_EVENT: begin
				if (list_active) begin
					last = (entry_ptr + 1) >= list_len;
					if (it.arb) begin
						r.clear_int = 1'b1;
						r.finish = FIN_ARB;
						list_active = 1'b0;
					end else if (it.nack) begin
						r.clear_int = 1'b1;
						r.finish = (bytes_left == 0 && last) ? FIN_OK : FIN_NACK;
						list_active = 1'b0;
					end else if (bytes_left == 0) begin
						if (last) begin
							r.clear_int = 1'b1;
							r.finish = FIN_OK;
							list_active = 1'b0;
						end else begin
							entry_ptr++;
							if (!open_next_entry(r)) begin
								r.clear_int = 1'b1;
								r.issue_stop = 1'b1;
								r.finish = FIN_PARAM;
								list_active = 1'b0;
							end
						end
					end else begin
						r.clear_int = 1'b1;
						if (bytes_left > 0) begin
							r.tx_load = 1'b1;
							r.tx_value = it.txb;
							r.tx_taken = 1'b1;
							r.issue_write = 1'b1;
							bytes_left--;
						end else begin
							// The first event of a read only launches the first byte.
							if (!first_rx_pending) begin
								r.rx_valid = 1'b1;
								r.rx_data = it.rxb;
								bytes_left++;
							end
							first_rx_pending = 1'b0;
							r.issue_read = 1'b1;
						end
						if (bytes_left == 0) begin
							r.send_nack = 1'b1;
							if (last)
								r.issue_stop = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Mostly short lengths with plenty of zeros; now and then a long one.
	function automatic logic signed [8:0] draw_length();
		int p;
		int mag;
		p = $urandom_range(0, 199);
		if (p < 2)
			mag = $urandom_range(200, 255);
		else if (p < 30)
			mag = $urandom_range(5, 20);
		else
			mag = $urandom_range(0, 4);
		return 9'($urandom_range(0, 1) ? -mag : mag);
	endfunction

	// Fill every field at random, ignored ones too.
	function automatic seq_item_t draw_item(logic [1:0] cmd);
		seq_item_t it;
		it.cmd = cmd;
		it.idx = 4'($urandom_range(0, 15));
		it.len = draw_length();
		it.cnt = 5'($urandom_range(0, 31));
		it.arb = 1'($urandom_range(0, 1));
		it.nack = 1'($urandom_range(0, 1));
		it.rxb = 8'($urandom);
		it.txb = 8'($urandom);
		return it;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatch_cnt++;
		end
	endfunction

	task automatic add_row(logic [1:0] cmd, int idx, int len, int cnt, bit arb, bit nack,
			logic [7:0] rxb, logic [7:0] txb, bit typed, logic [2:0] fin, bit clr);
		dir_row_t row;
		row.item.cmd = cmd;
		row.item.idx = idx[3:0];
		row.item.len = len[8:0];
		row.item.cnt = cnt[4:0];
		row.item.arb = arb;
		row.item.nack = nack;
		row.item.rxb = rxb;
		row.item.txb = txb;
		row.typed = typed;
		row.fin = fin;
		row.clr = clr;
		dir_tab.push_back(row);
	endtask

	// Offer one item after a random gap and hold it until the block takes it.
	// Predict at the accepting edge; leave tvalid high so a back-to-back item
	// follows without a bubble.
	task automatic send_item(seq_item_t it, bit use_given = 1'b0, result_t given = '0);
		int      gap;
		result_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {4'b0, it.txb, it.rxb, it.nack, it.arb, it.cnt, it.len, it.idx};
		do @(posedge clk); while (!s_tready);
		predicted = predict_bus_cmd(it);
		expected_cmds_q.push_back(use_given ? given : predicted);
		items_sent++;
	endtask

	task automatic write_slave_addr(logic [6:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		slave_addr_q = value;
	endtask

	// Random part of one phase: mostly complete lists driven to their finish,
	// with loads, stray starts and no-ops mixed in; the rest plain noise.
	task automatic run_random(int count);
		int        stop_at;
		seq_item_t it;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 99) < 80) begin
				repeat ($urandom_range(0, 6)) send_item(draw_item(CMD_LOAD));
				it = draw_item(CMD_START);
				case ($urandom_range(0, 9))
					0: it.cnt = 0;
					1: it.cnt = 5'($urandom_range(MAX_TRANS + 1, 31));
					default: it.cnt = 5'($urandom_range(1, MAX_TRANS));
				endcase
				send_item(it);
				while (list_active && items_sent < stop_at) begin
					case ($urandom_range(0, 39))
						0: send_item(draw_item(CMD_LOAD));
						1: send_item(draw_item(CMD_START));
						2: send_item(draw_item(CMD_NOP));
						default: begin
							it = draw_item(CMD_EVENT);
							it.arb = ($urandom_range(0, 99) == 0);
							it.nack = ($urandom_range(0, 59) == 0);
							send_item(it);
						end
					endcase
				end
			end else begin
				send_item(draw_item(2'($urandom_range(0, 3))));
			end
		end
		no_idle = 1'b0;
	endtask

	// End a phase with the block idle: abort a running list by an arbitration
	// loss, drop tvalid and drain every pending result.
	task automatic close_phase();
		seq_item_t it;
		if (list_active) begin
			it = draw_item(CMD_EVENT);
			it.arb = 1'b1;
			send_item(it);
		end
		s_tvalid <= 1'b0;
		while (expected_cmds_q.size() != 0)
			@(posedge clk);
	endtask

	// Result side: stall at random, honor a requested long hold-off, and check
	// every beat field by field against the oldest expectation.
	initial begin
		int          stall;
		result_t     want;
		logic [31:0] beat;
		m_tready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			beat = m_tdata;
			if (expected_cmds_q.size() == 0) begin
				$display("%0t: result beat with nothing pending, expected none actual %h",
					$time, beat);
				mismatch_cnt++;
			end else begin
				want = expected_cmds_q.pop_front();
				check_field("issue_start", 8'(want.issue_start), 8'(beat[0]));
				check_field("issue_write", 8'(want.issue_write), 8'(beat[1]));
				check_field("issue_read", 8'(want.issue_read), 8'(beat[2]));
				check_field("send_nack", 8'(want.send_nack), 8'(beat[3]));
				check_field("issue_stop", 8'(want.issue_stop), 8'(beat[4]));
				check_field("clear_int", 8'(want.clear_int), 8'(beat[5]));
				check_field("tx_load", 8'(want.tx_load), 8'(beat[6]));
				check_field("tx_value", want.tx_value, beat[14:7]);
				check_field("tx_taken", 8'(want.tx_taken), 8'(beat[15]));
				check_field("rx_valid", 8'(want.rx_valid), 8'(beat[16]));
				check_field("rx_data", want.rx_data, beat[24:17]);
				check_field("finish", 8'(want.finish), 8'(beat[27:25]));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		seq_item_t it;
		result_t   given;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_LOAD;
		items_sent = 0;
		mismatch_cnt = 0;
		hold_cycles = 0;
		no_idle = 1'b0;
		list_len = 0;
		entry_ptr = 0;
		bytes_left = 0;
		first_rx_pending = 1'b0;
		list_active = 1'b0;
		slave_addr_q = '0;
		foreach (len_tbl[i])
			len_tbl[i] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_slave_addr(7'd0);

		// Clear the whole table first so no list ever reaches an unloaded entry.
		for (int i = 0; i < MAX_TRANS; i++) begin
			it = draw_item(CMD_LOAD);
			it.idx = 4'(i);
			it.len = 0;
			send_item(it);
		end

		// Idle-state items: a bus event is ignored, an empty list and a list of
		// empty entries are bad parameters, a no-op does nothing.
		add_row(CMD_EVENT, 0, 0, 0, 1, 1, 8'hFF, 8'hFF, TYPED, FIN_NONE, 0);
		add_row(CMD_START, 0, 0, 0, 0, 0, 8'h00, 8'h00, TYPED, FIN_PARAM, 0);
		add_row(CMD_NOP, 15, 255, 31, 1, 1, 8'hFF, 8'hFF, TYPED, FIN_NONE, 0);
		add_row(CMD_START, 0, 0, 16, 0, 0, 8'h00, 8'h00, TYPED, FIN_PARAM, 0);
		// Length extremes, then an oversized count that saturates.
		add_row(CMD_LOAD, 0, 1, 0, 0, 0, 8'h00, 8'h00, TYPED, FIN_NONE, 0);
		add_row(CMD_LOAD, 15, -255, 0, 0, 0, 8'h00, 8'h00, TYPED, FIN_NONE, 0);
		add_row(CMD_LOAD, 3, 2, 0, 0, 0, 8'h00, 8'h00, TYPED, FIN_NONE, 0);
		add_row(CMD_START, 0, 0, 31, 0, 0, 8'h00, 8'h00, PRED, FIN_NONE, 0);
		// A start while a list runs is ignored.
		add_row(CMD_START, 0, 0, 1, 0, 0, 8'h00, 8'h00, TYPED, FIN_NONE, 0);
		// Write one byte, skip the empty entries, then a NACK mid-write.
		add_row(CMD_EVENT, 0, 0, 0, 0, 0, 8'h00, 8'hA5, PRED, FIN_NONE, 0);
		add_row(CMD_EVENT, 0, 0, 0, 0, 0, 8'h00, 8'h00, PRED, FIN_NONE, 0);
		add_row(CMD_EVENT, 0, 0, 0, 0, 1, 8'h00, 8'h00, TYPED, FIN_NACK, 1);
		// Two-byte read as the last entry, ended by a NACK that counts as ok.
		add_row(CMD_LOAD, 3, -2, 0, 0, 0, 8'h00, 8'h00, TYPED, FIN_NONE, 0);
		add_row(CMD_LOAD, 0, 0, 0, 0, 0, 8'h00, 8'h00, TYPED, FIN_NONE, 0);
		add_row(CMD_START, 0, 0, 4, 0, 0, 8'h00, 8'h00, PRED, FIN_NONE, 0);
		add_row(CMD_EVENT, 0, 0, 0, 0, 0, 8'h00, 8'h00, PRED, FIN_NONE, 0);
		add_row(CMD_EVENT, 0, 0, 0, 0, 0, 8'hFF, 8'h00, PRED, FIN_NONE, 0);
		add_row(CMD_EVENT, 0, 0, 0, 0, 0, 8'h00, 8'h00, PRED, FIN_NONE, 0);
		add_row(CMD_EVENT, 0, 0, 0, 0, 1, 8'h00, 8'h00, PRED, FIN_NONE, 0);
		// Arbitration loss wins over a NACK in the same event.
		add_row(CMD_START, 0, 0, 16, 0, 0, 8'h00, 8'h00, PRED, FIN_NONE, 0);
		add_row(CMD_EVENT, 0, 0, 0, 1, 1, 8'h00, 8'h00, TYPED, FIN_ARB, 1);
		// Nothing left after the only entry: stop with a bad-parameter finish.
		add_row(CMD_LOAD, 3, 1, 0, 0, 0, 8'h00, 8'h00, TYPED, FIN_NONE, 0);
		add_row(CMD_LOAD, 15, 0, 0, 0, 0, 8'h00, 8'h00, TYPED, FIN_NONE, 0);
		add_row(CMD_START, 0, 0, 16, 0, 0, 8'h00, 8'h00, PRED, FIN_NONE, 0);
		add_row(CMD_EVENT, 0, 0, 0, 0, 0, 8'h00, 8'h5A, PRED, FIN_NONE, 0);
		add_row(CMD_EVENT, 0, 0, 0, 0, 0, 8'h00, 8'h00, PRED, FIN_NONE, 0);

		foreach (dir_tab[i]) begin
			given = '0;
			given.finish = dir_tab[i].fin;
			given.clear_int = dir_tab[i].clr;
			send_item(dir_tab[i].item, dir_tab[i].typed, given);
		end

		run_random(300);
		close_phase();

		// Hold the result side off for a long stretch so the block backs up.
		write_slave_addr(7'h7F);
		hold_cycles = HOLD_OFF_CYCLES;
		run_random(350);
		close_phase();

		write_slave_addr(7'h55);
		run_random(350);
		close_phase();

		write_slave_addr(7'($urandom_range(1, 126)));
		run_random(350);
		close_phase();

		write_slave_addr(7'h2A);
		run_random(300);
		close_phase();

		// Catch any stray beat after the last expected one.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
